/* sv/tcw_pkg.sv */
// Shared constants, types and the cell address function of the text console writer.
package tcw_pkg;

  // Screen geometry
  localparam int ROWS      = 24;
  localparam int COLS      = 80;
  localparam int TAB_CELLS = 4;
  localparam int CELLS     = ROWS * COLS;

  // Internal widths; the row also holds the pending-wrap row and a short overshoot
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS + 3);
  localparam int COL_W  = $clog2(COLS);
  localparam int TAB_W  = $clog2(TAB_CELLS + 1);
  localparam int CELL_W = 16;

  // Port field widths
  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int RROW_W  = 5;
  localparam int RCOL_W  = 7;
  localparam int CROW_W  = 5;
  localparam int CCOL_W  = 7;
  localparam int COLOR_W = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [TAB_W-1:0]   tab_cnt_t;
  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [RROW_W-1:0]  rrow_t;
  typedef logic [RCOL_W-1:0]  rcol_t;
  typedef logic [CROW_W-1:0]  crow_t;
  typedef logic [CCOL_W-1:0]  ccol_t;
  typedef logic [COLOR_W-1:0] color_t;

  // Commands
  localparam cmd_t CMD_PUT   = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  // Control characters
  localparam char_t CH_BACKSPACE = 8'd8;
  localparam char_t CH_TAB       = 8'd9;
  localparam char_t CH_NEWLINE   = 8'd10;
  localparam char_t CH_SPACE     = 8'h20;
  localparam char_t RESET_ATTR   = 8'h04;

  // Register map (index is byte address / 4)
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;
  localparam color_t FG_RESET = 4'd4;
  localparam color_t BG_RESET = 4'd0;

  // Scroll copy and sweep bounds
  localparam addr_t LAST_CELL      = addr_t'(CELLS - 1);
  localparam addr_t LAST_ROW_BASE  = addr_t'(CELLS - COLS);
  localparam logic [ADDR_W:0] SRC_OFS = (ADDR_W + 1)'(COLS);

  // Cell engine operations
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_FILL,
    OP_SCROLL
  } eng_op_t;

  typedef struct packed {
    logic    valid;
    eng_op_t op;
    addr_t   addr;
    cell_t   data;
  } eng_req_t;

  typedef struct packed {
    logic  done;
    cell_t rdata;
  } eng_stat_t;

  // Linear cell address of a row and column
  function automatic addr_t cell_addr(input row_t row, input col_t col);
    return addr_t'(32'(row) * 32'(COLS) + 32'(col));
  endfunction

endpackage

/* sv/tcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1920
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/tcw_cell_engine.sv */
// Cell engine: owns the screen RAM and runs single accesses, fill sweeps and scroll copies.
module tcw_cell_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  tcw_pkg::eng_req_t  req,
  output tcw_pkg::eng_stat_t stat
);

  typedef enum logic [2:0] {
    E_IDLE,
    E_READ,
    E_FILL,
    E_SCROLL,
    E_DRAIN
  } eng_state_t;

  eng_state_t     state_r;
  tcw_pkg::addr_t ptr_r;
  tcw_pkg::addr_t wptr_r;
  tcw_pkg::cell_t data_r;
  tcw_pkg::cell_t rdata_r;
  logic           wvalid_r;
  logic           wzero_r;
  logic           done_r;

  logic                    ram_we;
  logic                    ram_re;
  tcw_pkg::addr_t          ram_waddr;
  tcw_pkg::addr_t          ram_raddr;
  tcw_pkg::cell_t          ram_wdata;
  tcw_pkg::cell_t          ram_rdata;
  logic [tcw_pkg::ADDR_W:0] src_sum;
  logic                    src_zero;

  // Source of a scroll copy sits one row below the destination
  assign src_sum  = {1'b0, ptr_r} + tcw_pkg::SRC_OFS;
  assign src_zero = (ptr_r >= tcw_pkg::LAST_ROW_BASE);

  // Drive the RAM ports from the current operation
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = data_r;
    ram_re    = 1'b0;
    ram_raddr = ptr_r;
    unique case (state_r)
      E_IDLE: begin
        if (req.valid && (req.op == tcw_pkg::OP_WRITE)) begin
          ram_we    = 1'b1;
          ram_waddr = req.addr;
          ram_wdata = req.data;
        end
        if (req.valid && (req.op == tcw_pkg::OP_READ)) begin
          ram_re    = 1'b1;
          ram_raddr = req.addr;
        end
      end
      E_FILL: begin
        ram_we = 1'b1;
      end
      E_SCROLL, E_DRAIN: begin
        ram_re    = (state_r == E_SCROLL) && !src_zero;
        ram_raddr = src_sum[tcw_pkg::ADDR_W-1:0];
        ram_we    = wvalid_r;
        ram_waddr = wptr_r;
        ram_wdata = wzero_r ? '0 : ram_rdata;
      end
      default: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(tcw_pkg::CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequence the operation and flag completion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= E_IDLE;
      done_r   <= 1'b0;
      wvalid_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        E_IDLE: begin
          if (req.valid) begin
            unique case (req.op)
              tcw_pkg::OP_WRITE: begin
                done_r <= 1'b1;
              end
              tcw_pkg::OP_READ: begin
                state_r <= E_READ;
              end
              tcw_pkg::OP_FILL: begin
                ptr_r   <= '0;
                data_r  <= req.data;
                state_r <= E_FILL;
              end
              tcw_pkg::OP_SCROLL: begin
                ptr_r    <= '0;
                wvalid_r <= 1'b0;
                state_r  <= E_SCROLL;
              end
              default: begin
              end
            endcase
          end
        end
        E_READ: begin
          rdata_r <= ram_rdata;
          done_r  <= 1'b1;
          state_r <= E_IDLE;
        end
        E_FILL: begin
          if (ptr_r == tcw_pkg::LAST_CELL) begin
            done_r  <= 1'b1;
            state_r <= E_IDLE;
          end else begin
            ptr_r <= ptr_r + tcw_pkg::addr_t'(1);
          end
        end
        E_SCROLL: begin
          // Read this cell's source now, write it when the data lands
          wvalid_r <= 1'b1;
          wptr_r   <= ptr_r;
          wzero_r  <= src_zero;
          if (ptr_r == tcw_pkg::LAST_CELL) begin
            state_r <= E_DRAIN;
          end else begin
            ptr_r <= ptr_r + tcw_pkg::addr_t'(1);
          end
        end
        E_DRAIN: begin
          wvalid_r <= 1'b0;
          done_r   <= 1'b1;
          state_r  <= E_IDLE;
        end
        default: begin
          state_r <= E_IDLE;
        end
      endcase
    end
  end

  assign stat.done  = done_r;
  assign stat.rdata = rdata_r;

endmodule

/* sv/text_console_writer_unit.sv */
// Top level of the text console writer: command sequencer, cursor, registers and ports.
//
// A 24 by 80 text screen held in one RAM of 16-bit cells (attribute in the high byte,
// character in the low byte), with a linear cursor. Every input item gives exactly one
// result item carrying the read cell (zero unless the command is a read) and the cursor
// after the command. The block takes one item at a time and holds in_stall high while
// it works. A clear, and every scroll, is a sweep of the RAM through its single write
// port, one cell a cycle, and a newline from the pending-wrap position scrolls twice.
// After reset the block fills the screen with spaces in attribute 0x04 before it takes
// its first item; register writes are taken at any time. Registers: fg_color at byte
// address 0, bg_color at byte address 4, each in the low four bits.
module text_console_writer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tcw_pkg::cmd_t                 in_cmd,
  input  tcw_pkg::char_t                in_char_code,
  input  tcw_pkg::rrow_t                in_read_row,
  input  tcw_pkg::rcol_t                in_read_col,
  // Result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output tcw_pkg::char_t                out_cell_char,
  output tcw_pkg::char_t                out_cell_attr,
  output tcw_pkg::crow_t                out_cursor_row,
  output tcw_pkg::ccol_t                out_cursor_col,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0]   paddr,
  input  logic [tcw_pkg::PDATA_W-1:0]   pwdata,
  output logic [tcw_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_TAB,
    S_SCROLL_CHK,
    S_PUT,
    S_BS_WRITE,
    S_WAIT_FIN
  } state_t;

  // Sequencer state
  state_t            state_r;
  state_t            ret_r;
  logic              waiting_r;
  tcw_pkg::row_t     row_r;
  tcw_pkg::col_t     col_r;
  tcw_pkg::tab_cnt_t tab_cnt_r;

  // Latched item
  tcw_pkg::cmd_t     cmd_r;
  tcw_pkg::char_t    ch_r;
  tcw_pkg::rrow_t    rr_r;
  tcw_pkg::rcol_t    rc_r;
  tcw_pkg::char_t    rd_char_r;
  tcw_pkg::char_t    rd_attr_r;

  // Result register
  logic              out_valid_r;
  tcw_pkg::char_t    out_char_r;
  tcw_pkg::char_t    out_attr_r;
  tcw_pkg::crow_t    out_row_r;
  tcw_pkg::ccol_t    out_col_r;

  // Colour registers
  tcw_pkg::color_t   fg_r;
  tcw_pkg::color_t   bg_r;

  tcw_pkg::eng_req_t  eng_req;
  tcw_pkg::eng_stat_t eng_stat;
  tcw_pkg::char_t     cur_attr;
  tcw_pkg::row_t      addr_row;
  tcw_pkg::col_t      addr_col;
  tcw_pkg::addr_t     cur_addr;
  logic               accept;
  logic               out_free;
  logic               read_ok;
  logic               at_origin;
  logic               need_scroll;

  assign cur_attr    = {bg_r, fg_r};
  assign accept      = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign read_ok     = (rr_r < tcw_pkg::ROWS) && (rc_r < tcw_pkg::COLS);
  assign at_origin   = (row_r == '0) && (col_r == '0);
  assign need_scroll = (row_r >= tcw_pkg::ROWS);

  // Shared address unit: the read cell while decoding, the cursor otherwise
  assign addr_row = (state_r == S_DECODE) ? tcw_pkg::row_t'(rr_r) : row_r;
  assign addr_col = (state_r == S_DECODE) ? tcw_pkg::col_t'(rc_r) : col_r;
  assign cur_addr = tcw_pkg::cell_addr(addr_row, addr_col);

  // Issue engine operations from the issuing states
  always_comb begin
    eng_req.valid = 1'b0;
    eng_req.op    = tcw_pkg::OP_WRITE;
    eng_req.addr  = cur_addr;
    eng_req.data  = {cur_attr, tcw_pkg::CH_SPACE};
    unique case (state_r)
      S_INIT: begin
        eng_req.valid = !waiting_r;
        eng_req.op    = tcw_pkg::OP_FILL;
        eng_req.data  = {tcw_pkg::RESET_ATTR, tcw_pkg::CH_SPACE};
      end
      S_DECODE: begin
        unique case (cmd_r)
          tcw_pkg::CMD_PUT: begin
            if ((ch_r != tcw_pkg::CH_NEWLINE) && (ch_r != tcw_pkg::CH_TAB) &&
                (ch_r != tcw_pkg::CH_BACKSPACE) && need_scroll) begin
              eng_req.valid = 1'b1;
              eng_req.op    = tcw_pkg::OP_SCROLL;
            end
          end
          tcw_pkg::CMD_READ: begin
            eng_req.valid = read_ok;
            eng_req.op    = tcw_pkg::OP_READ;
          end
          tcw_pkg::CMD_CLEAR: begin
            eng_req.valid = 1'b1;
            eng_req.op    = tcw_pkg::OP_FILL;
          end
          default: begin
          end
        endcase
      end
      S_SCROLL_CHK: begin
        eng_req.valid = need_scroll;
        eng_req.op    = tcw_pkg::OP_SCROLL;
      end
      S_PUT: begin
        eng_req.valid = 1'b1;
        eng_req.data  = {cur_attr, ch_r};
      end
      S_BS_WRITE: begin
        eng_req.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tcw_cell_engine u_engine (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (eng_req),
    .stat (eng_stat)
  );

  // Command sequencer, cursor and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ret_r       <= S_IDLE;
      waiting_r   <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once taken
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          // Reset fill: wait for the sweep to finish
          waiting_r <= 1'b1;
          if (eng_stat.done) begin
            waiting_r <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r   <= in_cmd;
            ch_r    <= in_char_code;
            rr_r    <= in_read_row;
            rc_r    <= in_read_col;
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          rd_char_r <= '0;
          rd_attr_r <= '0;
          ret_r     <= S_IDLE;
          state_r   <= S_WAIT_FIN;
          unique case (cmd_r)
            tcw_pkg::CMD_PUT: begin
              if (ch_r == tcw_pkg::CH_NEWLINE) begin
                row_r   <= row_r + tcw_pkg::row_t'(1);
                col_r   <= '0;
                state_r <= S_SCROLL_CHK;
              end else if (ch_r == tcw_pkg::CH_TAB) begin
                tab_cnt_r <= tcw_pkg::tab_cnt_t'(tcw_pkg::TAB_CELLS);
                state_r   <= S_TAB;
              end else if (ch_r == tcw_pkg::CH_BACKSPACE) begin
                // Step back onto the previous cell; nothing at the origin
                if (!at_origin) begin
                  if (col_r == '0) begin
                    col_r <= tcw_pkg::col_t'(tcw_pkg::COLS - 1);
                    row_r <= row_r - tcw_pkg::row_t'(1);
                  end else begin
                    col_r <= col_r - tcw_pkg::col_t'(1);
                  end
                  state_r <= S_BS_WRITE;
                end
              end else if (need_scroll) begin
                // Pending wrap: scroll once, then write on the last row
                row_r   <= row_r - tcw_pkg::row_t'(1);
                ret_r   <= S_PUT;
                waiting_r <= 1'b1;
              end else begin
                state_r <= S_PUT;
              end
            end
            tcw_pkg::CMD_READ: begin
              waiting_r <= read_ok;
            end
            tcw_pkg::CMD_CLEAR: begin
              row_r     <= '0;
              col_r     <= '0;
              waiting_r <= 1'b1;
            end
            default: begin
            end
          endcase
        end
        S_TAB: begin
          // Advance one cell a cycle
          if (col_r == tcw_pkg::col_t'(tcw_pkg::COLS - 1)) begin
            col_r <= '0;
            row_r <= row_r + tcw_pkg::row_t'(1);
          end else begin
            col_r <= col_r + tcw_pkg::col_t'(1);
          end
          tab_cnt_r <= tab_cnt_r - tcw_pkg::tab_cnt_t'(1);
          if (tab_cnt_r == tcw_pkg::tab_cnt_t'(1)) begin
            state_r <= S_SCROLL_CHK;
          end
        end
        S_SCROLL_CHK: begin
          // Scroll until the cursor sits on a real row
          state_r <= S_WAIT_FIN;
          ret_r   <= S_IDLE;
          if (need_scroll) begin
            row_r     <= row_r - tcw_pkg::row_t'(1);
            ret_r     <= S_SCROLL_CHK;
            waiting_r <= 1'b1;
          end
        end
        S_PUT: begin
          // Write the character and advance the cursor
          if (col_r == tcw_pkg::col_t'(tcw_pkg::COLS - 1)) begin
            col_r <= '0;
            row_r <= row_r + tcw_pkg::row_t'(1);
          end else begin
            col_r <= col_r + tcw_pkg::col_t'(1);
          end
          ret_r     <= S_IDLE;
          waiting_r <= 1'b1;
          state_r   <= S_WAIT_FIN;
        end
        S_BS_WRITE: begin
          ret_r     <= S_IDLE;
          waiting_r <= 1'b1;
          state_r   <= S_WAIT_FIN;
        end
        S_WAIT_FIN: begin
          if (waiting_r) begin
            // Hold until the engine reports completion
            if (eng_stat.done) begin
              waiting_r <= 1'b0;
              if (cmd_r == tcw_pkg::CMD_READ) begin
                rd_char_r <= eng_stat.rdata[7:0];
                rd_attr_r <= eng_stat.rdata[15:8];
              end
              if (ret_r != S_IDLE) begin
                state_r <= ret_r;
              end
            end
          end else if (out_free) begin
            // Present the result
            out_valid_r <= 1'b1;
            out_char_r  <= rd_char_r;
            out_attr_r  <= rd_attr_r;
            out_row_r   <= tcw_pkg::crow_t'(row_r);
            out_col_r   <= tcw_pkg::ccol_t'(col_r);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Colour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= tcw_pkg::FG_RESET;
      bg_r <= tcw_pkg::BG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == tcw_pkg::REG_BG) begin
        bg_r <= pwdata[tcw_pkg::COLOR_W-1:0];
      end else begin
        fg_r <= pwdata[tcw_pkg::COLOR_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == tcw_pkg::REG_BG) ? tcw_pkg::PDATA_W'(bg_r)
                                                : tcw_pkg::PDATA_W'(fg_r);
  assign pready = 1'b1;

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;

endmodule
